/* rtl/sbu_pkg.sv */
// ----------------------------------------------------------------------------
// sbu_pkg: shared types and constants of the script branch unit
// Opcode and error codes, stack sizing and the word layouts that pass
// between the top level and the execute stage.
// ----------------------------------------------------------------------------
package sbu_pkg;

    // Return stack sizing
    localparam int STACK_DEPTH = 8;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Loop label that marks no active loop
    localparam logic [15:0] NO_LOOP = 16'hFFFF;

    typedef enum logic [3:0] {
        OP_JUMP      = 4'd0,
        OP_FAR_JUMP  = 4'd1,
        OP_COND_JUMP = 4'd2,
        OP_CALL      = 4'd3,
        OP_FAR_CALL  = 4'd4,
        OP_RETURN    = 4'd5,
        OP_RETURN_IF = 4'd6,
        OP_COND_RET  = 4'd7,
        OP_LOOP      = 4'd8,
        OP_SWITCH    = 4'd9,
        OP_CASE      = 4'd10
    } opcode_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNDERFLOW = 2'd2
    } error_t;

    // One decoded instruction word
    typedef struct packed {
        logic [3:0]         opcode;
        logic [31:0]        target_address;
        logic [3:0]         target_buffer;
        logic [31:0]        next_ip;
        logic [3:0]         current_buffer;
        logic               condition;
        logic               expected;
        logic [15:0]        loop_label;
        logic signed [31:0] loop_count;
        logic signed [31:0] operand_value;
    } item_t;

    // One result word
    typedef struct packed {
        logic [31:0] new_ip;
        logic [3:0]  new_buffer;
        logic        taken;
        logic [1:0]  error;
        logic [3:0]  depth_now;
    } result_t;

endpackage

/* rtl/sbu_exec.sv */
// ----------------------------------------------------------------------------
// sbu_exec: execute stage of the script branch unit
// Holds the return stack, loop counter and switch value, resolves one
// instruction per cycle combinationally and commits state when fired.
// ----------------------------------------------------------------------------
module sbu_exec
    import sbu_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  item_t   item,
    output result_t result
);

    // Return stack storage, no reset needed
    logic [31:0] ip_stack_reg  [STACK_DEPTH];
    logic [3:0]  buf_stack_reg [STACK_DEPTH];

    logic [DEPTH_W-1:0] depth_reg,    depth_next;
    logic [15:0]        label_reg,    label_next;
    logic [31:0]        remain_reg,   remain_next;
    logic [31:0]        switch_reg,   switch_next;

    logic               match;
    logic               full;
    logic               empty;
    logic [DEPTH_W-1:0] depth_dec;
    logic [PTR_W-1:0]   top_idx;
    logic [PTR_W-1:0]   push_idx;
    logic [31:0]        pop_ip;
    logic [3:0]         pop_buf;
    logic               push_en;
    logic [31:0]        loop_cur;
    logic [31:0]        loop_dec;

    assign match     = (item.condition == item.expected);
    assign full      = (depth_reg == DEPTH_W'(STACK_DEPTH));
    assign empty     = (depth_reg == '0);
    assign depth_dec = depth_reg - DEPTH_W'(1);
    assign top_idx   = depth_dec[PTR_W-1:0];
    assign push_idx  = depth_reg[PTR_W-1:0];
    assign pop_ip    = ip_stack_reg[top_idx];
    assign pop_buf   = buf_stack_reg[top_idx];

    // Continue the stored count on a label match, else restart it
    assign loop_cur = (label_reg != item.loop_label) ? 32'(item.loop_count) : remain_reg;
    assign loop_dec = loop_cur - 32'd1;

    // Resolve the instruction
    always_comb begin
        result.new_ip     = item.next_ip;
        result.new_buffer = item.current_buffer;
        result.taken      = 1'b0;
        result.error      = ERR_NONE;
        depth_next        = depth_reg;
        label_next        = label_reg;
        remain_next       = remain_reg;
        switch_next       = switch_reg;
        push_en           = 1'b0;

        unique case (item.opcode)
            OP_JUMP: begin
                result.new_ip = item.target_address;
                result.taken  = 1'b1;
            end
            OP_FAR_JUMP: begin
                result.new_ip     = item.target_address;
                result.new_buffer = item.target_buffer;
                result.taken      = 1'b1;
            end
            OP_COND_JUMP: begin
                if (match) begin
                    result.new_ip = item.target_address;
                    result.taken  = 1'b1;
                end
            end
            OP_CALL, OP_FAR_CALL: begin
                if (full) begin
                    result.error = ERR_OVERFLOW;
                end else begin
                    push_en       = 1'b1;
                    depth_next    = depth_reg + DEPTH_W'(1);
                    result.new_ip = item.target_address;
                    result.taken  = 1'b1;
                    if (item.opcode == OP_FAR_CALL) begin
                        result.new_buffer = item.target_buffer;
                    end
                end
            end
            OP_RETURN: begin
                if (empty) begin
                    result.error = ERR_UNDERFLOW;
                end else begin
                    depth_next        = depth_dec;
                    result.new_ip     = pop_ip;
                    result.new_buffer = pop_buf;
                    result.taken      = 1'b1;
                end
            end
            OP_RETURN_IF: begin
                // Depth is checked before the condition
                if (empty) begin
                    result.error = ERR_UNDERFLOW;
                end else if (match) begin
                    depth_next        = depth_dec;
                    result.new_ip     = pop_ip;
                    result.new_buffer = pop_buf;
                    result.taken      = 1'b1;
                end
            end
            OP_COND_RET: begin
                // Condition is checked before the depth
                if (match) begin
                    if (empty) begin
                        result.error = ERR_UNDERFLOW;
                    end else begin
                        depth_next        = depth_dec;
                        result.new_ip     = pop_ip;
                        result.new_buffer = pop_buf;
                        result.taken      = 1'b1;
                    end
                end
            end
            OP_LOOP: begin
                remain_next = loop_dec;
                if (loop_dec != 32'd0) begin
                    label_next    = item.loop_label;
                    result.new_ip = item.target_address;
                    result.taken  = 1'b1;
                end else begin
                    label_next = NO_LOOP;
                end
            end
            OP_SWITCH: begin
                switch_next = 32'(item.operand_value);
            end
            OP_CASE: begin
                if (switch_reg == 32'(item.operand_value)) begin
                    result.new_ip = item.target_address;
                    result.taken  = 1'b1;
                end
            end
            default: begin
            end
        endcase

        result.depth_now = 4'(depth_next);
    end

    // Commit control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg  <= '0;
            label_reg  <= NO_LOOP;
            remain_reg <= '0;
            switch_reg <= '0;
        end else if (fire) begin
            depth_reg  <= depth_next;
            label_reg  <= label_next;
            remain_reg <= remain_next;
            switch_reg <= switch_next;
        end
    end

    // Push the return frame
    always_ff @(posedge aclk) begin
        if (fire && push_en) begin
            ip_stack_reg[push_idx]  <= item.next_ip;
            buf_stack_reg[push_idx] <= item.current_buffer;
        end
    end

endmodule

/* rtl/script_branch_unit_with_call_stack_top.sv */
// ----------------------------------------------------------------------------
// script_branch_unit_with_call_stack_top: branch unit with return stack
// Input register, combinational execute stage and output register for
// control-flow instructions of a script machine.
// ----------------------------------------------------------------------------
//
//  Channel | Ports     | Word
//  --------+-----------+-------------------------------------------------
//  input   | s_valid   | opcode, targets, next_ip, buffers, condition,
//          | s_ready   | loop label and count, operand value
//  result  | m_valid   | new_ip, new_buffer, taken, error, depth_now
//          | m_ready   |
//
//  One word per cycle sustained while m_ready holds; the result is registered,
//  executing from the input register into the output register.
//  The execute stage resolves the word and updates stack, loop and switch
//  state in the same cycle, so each word sees the state left by the last.
//  Synchronous active-low reset clears depth, loop and switch state; stack
//  entries are not cleared. A stalled result holds the output word; the
//  input register takes one more word and then drops s_ready.
//
module script_branch_unit_with_call_stack_top
    import sbu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_opcode,
    input  logic [31:0] s_target_address,
    input  logic [3:0]  s_target_buffer,
    input  logic [31:0] s_next_ip,
    input  logic [3:0]  s_current_buffer,
    input  logic        s_condition,
    input  logic        s_expected,
    input  logic [15:0] s_loop_label,
    input  logic signed [31:0] s_loop_count,
    input  logic signed [31:0] s_operand_value,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_new_ip,
    output logic [3:0]  m_new_buffer,
    output logic        m_taken,
    output logic [1:0]  m_error,
    output logic [3:0]  m_depth_now
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t exec_result;
    logic    out_free;
    logic    fire;

    // Advance when the output slot is empty or draining
    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    // Hold the input word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.opcode         <= s_opcode;
            in_item_reg.target_address <= s_target_address;
            in_item_reg.target_buffer  <= s_target_buffer;
            in_item_reg.next_ip        <= s_next_ip;
            in_item_reg.current_buffer <= s_current_buffer;
            in_item_reg.condition      <= s_condition;
            in_item_reg.expected       <= s_expected;
            in_item_reg.loop_label     <= s_loop_label;
            in_item_reg.loop_count     <= s_loop_count;
            in_item_reg.operand_value  <= s_operand_value;
        end
    end

    sbu_exec u_exec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .result  (exec_result)
    );

    // Hold the result word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= exec_result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_new_ip     = out_reg.new_ip;
    assign m_new_buffer = out_reg.new_buffer;
    assign m_taken      = out_reg.taken;
    assign m_error      = out_reg.error;
    assign m_depth_now  = out_reg.depth_now;

endmodule

/* verif/sbu_branch_checker.sv */
// ----------------------------------------------------------------------------
// sbu_branch_checker: scoreboard for the script branch unit
// Watches both channels, runs its own copy of the return stack, loop counter
// and switch register on every accepted instruction word, and compares each
// result word field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module sbu_branch_checker
    import sbu_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,

    input  logic    s_valid,
    input  logic    s_ready,
    input  item_t   s_word,

    input  logic    m_valid,
    input  logic    m_ready,
    input  result_t m_word,

    output int      mismatches,
    output int      outstanding,
    output int      checked,
    output int      overflows,
    output int      underflows
);

    // Predicted machine state
    logic [31:0] ret_ip_mem  [STACK_DEPTH];
    logic [3:0]  ret_buf_mem [STACK_DEPTH];
    int          frames;
    logic [15:0] cur_label;
    logic [31:0] loop_left;
    logic [31:0] switch_val;

    // Results still owed by the block, oldest first
    result_t     branch_results_q[$];

    // Pop one frame into the result; caller has checked the stack is not empty
    function automatic void take_return(inout result_t r);
        frames--;
        r.new_ip     = ret_ip_mem[frames];
        r.new_buffer = ret_buf_mem[frames];
        r.taken      = 1'b1;
    endfunction

    // Execute one control-flow word against the predicted state
    function automatic result_t resolve_branch(input item_t w);
        result_t r;
        logic    cond_ok;
        r.new_ip     = w.next_ip;
        r.new_buffer = w.current_buffer;
        r.taken      = 1'b0;
        r.error      = ERR_NONE;
        cond_ok      = (w.condition == w.expected);
        case (w.opcode)
            OP_JUMP: begin
                r.new_ip = w.target_address;
                r.taken  = 1'b1;
            end
            OP_FAR_JUMP: begin
                r.new_ip     = w.target_address;
                r.new_buffer = w.target_buffer;
                r.taken      = 1'b1;
            end
            OP_COND_JUMP: begin
                if (cond_ok) begin
                    r.new_ip = w.target_address;
                    r.taken  = 1'b1;
                end
            end
            OP_CALL, OP_FAR_CALL: begin
                // a full stack leaves everything as it is
                if (frames < STACK_DEPTH) begin
                    ret_ip_mem[frames]  = w.next_ip;
                    ret_buf_mem[frames] = w.current_buffer;
                    frames++;
                    r.new_ip = w.target_address;
                    if (w.opcode == OP_FAR_CALL) r.new_buffer = w.target_buffer;
                    r.taken = 1'b1;
                end else begin
                    r.error = ERR_OVERFLOW;
                end
            end
            OP_RETURN: begin
                if (frames > 0) take_return(r);
                else r.error = ERR_UNDERFLOW;
            end
            OP_RETURN_IF: begin
                // depth first, condition second
                if (frames == 0) r.error = ERR_UNDERFLOW;
                else if (cond_ok) take_return(r);
            end
            OP_COND_RET: begin
                // condition first; a mismatch never reports an error
                if (cond_ok) begin
                    if (frames > 0) take_return(r);
                    else r.error = ERR_UNDERFLOW;
                end
            end
            OP_LOOP: begin
                if (cur_label != w.loop_label) begin
                    cur_label = w.loop_label;
                    loop_left = w.loop_count;
                end
                loop_left = loop_left - 32'd1;
                if (loop_left != 32'd0) begin
                    r.new_ip = w.target_address;
                    r.taken  = 1'b1;
                end else begin
                    cur_label = NO_LOOP;
                end
            end
            OP_SWITCH: switch_val = w.operand_value;
            OP_CASE: begin
                if (switch_val == w.operand_value) begin
                    r.new_ip = w.target_address;
                    r.taken  = 1'b1;
                end
            end
            default: ;
        endcase
        r.depth_now = 4'(frames);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v, act_v);
        if (act_v !== exp_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
        end
    endtask

    // Compare the result word first: it always belongs to an older instruction
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            frames     = 0;
            cur_label  = NO_LOOP;
            loop_left  = '0;
            switch_val = '0;
            branch_results_q.delete();
            outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (branch_results_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word with none expected, new_ip 0x%0h",
                             $time, m_word.new_ip);
                end else begin
                    want = branch_results_q.pop_front();
                    check_field("new_ip", want.new_ip, m_word.new_ip);
                    check_field("new_buffer", want.new_buffer, m_word.new_buffer);
                    check_field("taken", want.taken, m_word.taken);
                    check_field("error", want.error, m_word.error);
                    check_field("depth_now", want.depth_now, m_word.depth_now);
                    checked++;
                end
            end
            if (s_valid && s_ready) begin
                want = resolve_branch(s_word);
                if (want.error == ERR_OVERFLOW) overflows++;
                if (want.error == ERR_UNDERFLOW) underflows++;
                branch_results_q.push_back(want);
            end
            outstanding <= branch_results_q.size();
        end
    end

endmodule

/* verif/script_branch_unit_with_call_stack_top_tb.sv */
// ----------------------------------------------------------------------------
// script_branch_unit_with_call_stack_top_tb: testbench of the branch unit
// Sends a directed set of control-flow words, then random call/return,
// loop, switch/case and jump sequences with random gaps on both channels,
// a long result stall and a full drain; a checker scores every result word.
// ----------------------------------------------------------------------------
module script_branch_unit_with_call_stack_top_tb;
    import sbu_pkg::*;

    localparam int TOTAL_WORDS = 800;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    // Spare opcodes that the block must ignore
    localparam logic [3:0] OP_SPARE_LAST = 4'd15;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    item_t       in_word;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_new_ip;
    logic [3:0]  m_new_buffer;
    logic        m_taken;
    logic [1:0]  m_error;
    logic [3:0]  m_depth_now;
    result_t     out_word;

    int          mismatches;
    int          outstanding;
    int          checked;
    int          overflows;
    int          underflows;
    int          words_sent;
    bit          tx_idle;
    bit          rx_idle;
    bit          hold_start;

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    script_branch_unit_with_call_stack_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (in_word.opcode),
        .s_target_address (in_word.target_address),
        .s_target_buffer  (in_word.target_buffer),
        .s_next_ip        (in_word.next_ip),
        .s_current_buffer (in_word.current_buffer),
        .s_condition      (in_word.condition),
        .s_expected       (in_word.expected),
        .s_loop_label     (in_word.loop_label),
        .s_loop_count     (in_word.loop_count),
        .s_operand_value  (in_word.operand_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_new_ip         (m_new_ip),
        .m_new_buffer     (m_new_buffer),
        .m_taken          (m_taken),
        .m_error          (m_error),
        .m_depth_now      (m_depth_now)
    );

    assign out_word = {m_new_ip, m_new_buffer, m_taken, m_error, m_depth_now};

    sbu_branch_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_word      (in_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word      (out_word),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked),
        .overflows   (overflows),
        .underflows  (underflows)
    );

    // Instruction word with every field random
    function automatic item_t random_word(input logic [3:0] op);
        item_t w;
        w.opcode         = op;
        w.target_address = $urandom();
        w.target_buffer  = 4'($urandom_range(0, 15));
        w.next_ip        = $urandom();
        w.current_buffer = 4'($urandom_range(0, 15));
        w.condition      = 1'($urandom_range(0, 1));
        w.expected       = 1'($urandom_range(0, 1));
        w.loop_label     = 16'($urandom_range(0, 65535));
        w.loop_count     = $urandom();
        w.operand_value  = $urandom();
        return w;
    endfunction

    // Random word whose condition matches or misses on purpose
    function automatic item_t cond_word(input logic [3:0] op, input bit hit);
        item_t w;
        w = random_word(op);
        w.expected = hit ? w.condition : ~w.condition;
        return w;
    endfunction

    // Offer one word, with random gaps ahead of it, and hold it until accepted
    task automatic send_word(input item_t w);
        while (tx_idle && $urandom_range(0, 99) < 28) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        in_word <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (w.opcode <= OP_CASE) words_sent++;
    endtask

    // Stop offering until every predicted result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Result side: random back-pressure, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_start) begin
                hold_start = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !(rx_idle && $urandom_range(0, 99) < 28);
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        item_t       w;
        int          k;
        int          n;
        int          pick;
        logic [31:0] sel;
        bit          hold_done;
        bit          drain_done;

        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        in_word    <= '0;
        tx_idle    = 1'b1;
        rx_idle    = 1'b1;
        hold_start = 1'b0;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        words_sent = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Straight jumps at the address extremes, far jump, conditional jump
        w = random_word(OP_JUMP);
        w.target_address = '0;
        w.next_ip        = '1;
        send_word(w);
        w = random_word(OP_JUMP);
        w.target_address = '1;
        w.next_ip        = '0;
        send_word(w);
        w = random_word(OP_FAR_JUMP);
        w.target_buffer  = 4'hF;
        w.current_buffer = 4'h0;
        send_word(w);
        send_word(cond_word(OP_COND_JUMP, 1'b1));
        send_word(cond_word(OP_COND_JUMP, 1'b0));

        // Every return kind on an empty stack
        send_word(random_word(OP_RETURN));
        send_word(cond_word(OP_RETURN_IF, 1'b0));
        send_word(cond_word(OP_COND_RET, 1'b0));
        send_word(cond_word(OP_COND_RET, 1'b1));

        // Fill the stack, then call once more into a full stack
        for (k = 0; k < STACK_DEPTH; k++) begin
            w = random_word(k[0] ? OP_FAR_CALL : OP_CALL);
            if (k == 0) begin
                w.next_ip        = '1;
                w.current_buffer = 4'hF;
            end
            send_word(w);
        end
        send_word(random_word(OP_FAR_CALL));

        // Pop through each return kind, the first one missing its condition
        send_word(cond_word(OP_RETURN_IF, 1'b0));
        send_word(cond_word(OP_RETURN_IF, 1'b1));
        send_word(cond_word(OP_COND_RET, 1'b1));
        send_word(random_word(OP_RETURN));

        // Loop: new label, run out, idle-marker label, zero count wraps
        w = random_word(OP_LOOP);
        w.loop_label = 16'd5;
        w.loop_count = 2;
        send_word(w);
        w.target_address = $urandom();
        send_word(w);
        w = random_word(OP_LOOP);
        w.loop_label = NO_LOOP;
        w.loop_count = 32'sh80000000;
        send_word(w);
        w = random_word(OP_LOOP);
        w.loop_label = 16'd7;
        w.loop_count = 0;
        send_word(w);

        // Switch on the largest value, then a hit and a miss
        w = random_word(OP_SWITCH);
        w.operand_value = 32'sh7FFFFFFF;
        send_word(w);
        w = random_word(OP_CASE);
        w.operand_value = 32'sh7FFFFFFF;
        send_word(w);
        w = random_word(OP_CASE);
        w.operand_value = 32'sh80000000;
        send_word(w);
        send_word(random_word(OP_SPARE_LAST));

        // Random sequences; a gap-free stretch in the middle
        while (words_sent < TOTAL_WORDS) begin
            tx_idle = !(words_sent >= 250 && words_sent < 420);
            rx_idle = tx_idle;
            if (!hold_done && words_sent >= 420) begin
                hold_done  = 1'b1;
                hold_start = 1'b1;
            end
            if (!drain_done && words_sent >= 560) begin
                drain_done = 1'b1;
                drain_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                // burst of calls then returns: walks into full and empty stack
                n = $urandom_range(1, 9);
                repeat (n) send_word(random_word($urandom_range(0, 1) ? OP_CALL : OP_FAR_CALL));
                n = $urandom_range(1, 9);
                repeat (n) begin
                    k = $urandom_range(0, 2);
                    send_word(cond_word(k == 0 ? OP_RETURN :
                                        (k == 1 ? OP_RETURN_IF : OP_COND_RET),
                                        $urandom_range(0, 3) != 0));
                end
            end else if (pick < 50) begin
                // run a short loop to its end, or a few passes of a long one
                w = random_word(OP_LOOP);
                w.loop_label = ($urandom_range(0, 9) == 0) ? NO_LOOP
                                                           : 16'($urandom_range(0, 7));
                if ($urandom_range(0, 3) != 0) w.loop_count = $urandom_range(1, 6);
                n = (w.loop_count >= 1 && w.loop_count <= 8) ? w.loop_count
                                                               : $urandom_range(1, 4);
                repeat (n) begin
                    send_word(w);
                    w.target_address = $urandom();
                    w.next_ip        = $urandom();
                end
            end else if (pick < 65) begin
                // switch, then a few cases against it
                w = random_word(OP_SWITCH);
                if ($urandom_range(0, 1)) w.operand_value = $urandom_range(0, 3);
                send_word(w);
                sel = w.operand_value;
                n = $urandom_range(1, 4);
                repeat (n) begin
                    w = random_word(OP_CASE);
                    if ($urandom_range(0, 1)) w.operand_value = sel;
                    else if ($urandom_range(0, 1)) w.operand_value = $urandom_range(0, 3);
                    send_word(w);
                end
            end else if (pick < 85) begin
                k = $urandom_range(0, 2);
                send_word(cond_word(k == 0 ? OP_JUMP :
                                    (k == 1 ? OP_FAR_JUMP : OP_COND_JUMP),
                                    $urandom_range(0, 1)));
            end else begin
                // noise: any opcode, spare ones included
                send_word(random_word(4'($urandom_range(0, 15))));
            end
        end

        drain_results();
        repeat (10) @(posedge aclk);
        $display("Sent %0d control-flow words: jumps, call/return runs, loops, switch/case.",
                 words_sent);
        $display("Checked %0d results; %0d full-stack calls, %0d empty-stack returns.",
                 checked, overflows, underflows);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/sbu_pkg.sv
rtl/sbu_exec.sv
rtl/script_branch_unit_with_call_stack_top.sv
verif/sbu_branch_checker.sv
verif/script_branch_unit_with_call_stack_top_tb.sv
